### hw/rtl/shs_pkg.sv
`default_nettype none

package shs_pkg;

  typedef logic [31:0] word_t;

  // Eight 32-bit words; element 0 is a (or H0), element 7 is h (or H7).
  typedef logic [7:0][31:0] hash_t;

  localparam hash_t SHS_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] SHS_PAD_MARK = 8'h80;
  localparam logic [5:0] SHS_LEN_POS  = 6'd56;
  localparam logic [5:0] SHS_LAST_POS = 6'd63;

  // Round constants.
  function automatic word_t shs_k(input logic [5:0] idx);
    word_t k;
    begin
      unique case (idx)
        6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
        6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
        6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
        6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
        6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/shs_round.sv
`default_nettype none

module shs_round (
  input  wire shs_pkg::hash_t vars,
  input  wire shs_pkg::word_t k,
  input  wire shs_pkg::word_t w0,
  input  wire shs_pkg::word_t w1,
  input  wire shs_pkg::word_t w9,
  input  wire shs_pkg::word_t w14,
  output shs_pkg::hash_t vars_nxt,
  output shs_pkg::word_t w_new
);
  import shs_pkg::*;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t a, e, t1, t2, ssig0, ssig1;

  // One compression round: the window tap w0 is the schedule word of this round.
  always_comb begin
    a  = vars[0];
    e  = vars[4];
    t1 = vars[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & vars[5]) ^ (~e & vars[6])) + k + w0;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & vars[1]) ^ (a & vars[2]) ^ (vars[1] & vars[2]));
    vars_nxt[7] = vars[6];
    vars_nxt[6] = vars[5];
    vars_nxt[5] = vars[4];
    vars_nxt[4] = vars[3] + t1;
    vars_nxt[3] = vars[2];
    vars_nxt[2] = vars[1];
    vars_nxt[1] = vars[0];
    vars_nxt[0] = t1 + t2;
  end

  // Schedule expansion: the word sixteen rounds ahead of w0.
  always_comb begin
    ssig0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    ssig1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = ssig1 + w9 + ssig0 + w0;
  end

endmodule

`default_nettype wire

### hw/rtl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher.
// Input channel (in_valid, in_stall, in_op, in_data_byte): a transfer with
// in_op = 0 absorbs one message byte, a transfer with in_op = 1 ends the
// message. Output channel (out_valid, out_stall, out_digest_word, ...): after
// a finish the eight digest words leave as eight transfers, word 0 first,
// with out_last_word set on word 7.
// The 64th byte of a block starts a compression on the single shared round
// unit: 64 rounds at one per cycle, then a fold of the result into the
// chaining words, with in_stall high throughout. A finish feeds 9 to 72
// padding bytes through the same absorb path, one per cycle, with a
// compression each time a block fills, then presents the digest. The output
// words hold steady while out_stall is high, and the input side stays
// stalled until the last word's transfer completes.
// Reset (synchronous, rst_n low) loads the initial hash values and clears
// the byte count; the block is ready in the first cycle after reset.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import shs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Padding phases.
  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [2:0]   state_r;
  hash_t        chain_r;
  logic [63:0]  cnt_r;
  logic         fin_r;
  logic         done_r;
  logic [2:0]   idx_r;
  logic [5:0]   rnd_r;
  logic [1:0]   ph_r;
  logic [1:0]   ph_nxt;

  // The block buffer doubles as the sixteen-word schedule window.
  logic [511:0] blk_r;
  hash_t        vars_r;
  hash_t        vars_nxt;
  logic [63:0]  len_r;
  word_t        w_new;

  logic         abs_en;
  logic [7:0]   abs_byte;
  logic         len_shift;
  logic [5:0]   pos;
  logic         in_xfer;

  assign pos      = cnt_r[5:0];
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = chain_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  shs_round u_round (
    .vars     (vars_r),
    .k        (shs_k(rnd_r)),
    .w0       (blk_r[511:480]),
    .w1       (blk_r[479:448]),
    .w9       (blk_r[223:192]),
    .w14      (blk_r[63:32]),
    .vars_nxt (vars_nxt),
    .w_new    (w_new)
  );

  // Byte source for the absorb path: message bytes from the input channel,
  // or the marker, zero fill and bit length while finishing.
  always_comb begin
    abs_en    = 1'b0;
    abs_byte  = '0;
    len_shift = 1'b0;
    ph_nxt    = ph_r;
    if (state_r == S_IDLE && in_xfer && !in_op) begin
      abs_en   = 1'b1;
      abs_byte = in_data_byte;
    end else if (state_r == S_IDLE && in_xfer && in_op) begin
      // A finish always starts its padding with the marker byte.
      ph_nxt = PH_MARK;
    end else if (state_r == S_PAD) begin
      abs_en = 1'b1;
      unique case (ph_r)
        PH_MARK: begin
          abs_byte = SHS_PAD_MARK;
          ph_nxt   = PH_ZERO;
        end
        PH_ZERO: begin
          if (pos == SHS_LEN_POS) begin
            abs_byte  = len_r[63:56];
            len_shift = 1'b1;
            ph_nxt    = PH_LEN;
          end
        end
        PH_LEN: begin
          abs_byte  = len_r[63:56];
          len_shift = 1'b1;
        end
        default: ph_nxt = PH_MARK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chain_r <= SHS_IV;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
      rnd_r   <= '0;
      ph_r    <= PH_MARK;
    end else begin
      ph_r <= ph_nxt;
      if (abs_en) begin
        cnt_r <= cnt_r + 64'd1;
        if (pos == SHS_LAST_POS) begin
          state_r <= S_RND;
          rnd_r   <= '0;
          // The last length byte closes the message.
          if (state_r == S_PAD && ph_r == PH_LEN) begin
            done_r <= 1'b1;
          end
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && in_op) begin
            fin_r   <= 1'b1;
            state_r <= S_PAD;
          end
        end
        S_PAD: begin
        end
        S_RND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == SHS_LAST_POS) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + vars_r[i];
          end
          done_r <= 1'b0;
          if (done_r) begin
            state_r <= S_OUT;
          end else if (fin_r) begin
            state_r <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              chain_r <= SHS_IV;
              cnt_r   <= '0;
              fin_r   <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (abs_en) begin
      blk_r <= {blk_r[503:0], abs_byte};
      if (pos == SHS_LAST_POS) begin
        vars_r <= chain_r;
      end
    end else if (state_r == S_RND) begin
      blk_r  <= {blk_r[479:0], w_new};
      vars_r <= vars_nxt;
    end
    if (state_r == S_IDLE && in_xfer && in_op) begin
      len_r <= {cnt_r[60:0], 3'b000};
    end else if (len_shift) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

endmodule

`default_nettype wire

### tb/sv/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  typedef shs_pkg::word_t word_t;

  // Input operation codes carried by in_op.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Round constants and the initial hash value. Both are written in natural
  // order: with an ascending packed range, element 0 is the leftmost entry.
  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Input items for the run; random messages are sent until this count is reached.
  localparam int TOTAL_ITEMS = 470;

  // One digest word as it should leave the output channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  // Every input of the block starts at a known value; reset is held low
  // from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_op = OP_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always #6 clk = ~clk;

  // Hash state of the predictor: chaining words, the partial block and the
  // running byte count of the current message.
  word_t       hash_chain [8];
  logic [7:0]  block_bytes [64];
  logic [63:0] byte_count;

  // Digest words predicted but not yet seen on the output channel.
  digest_beat_t pending_words [$];

  int mismatch_count = 0;
  int items_sent = 0;

  // When this is clear, the sender never pauses and the receiver never
  // stalls, so both channels run as fast as the block allows.
  bit idle_on = 1'b1;
  int burst_left = 0;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 8; i++) hash_chain[i] = START_HASH[i];
    byte_count = '0;
  endfunction

  // Runs the 64 rounds over the block held in block_bytes and folds the
  // working variables back into the chaining words.
  function automatic void compress_block();
    word_t sched [16];
    word_t v [8];
    word_t w, s0, s1, t1, t2;
    int    r;
    for (r = 0; r < 16; r++) begin
      sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                  block_bytes[4*r+3]};
    end
    for (r = 0; r < 8; r++) v[r] = hash_chain[r];
    for (r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = sched[r];
      end else begin
        s1 = rotr(sched[(r-2) & 15], 17) ^ rotr(sched[(r-2) & 15], 19) ^
             (sched[(r-2) & 15] >> 10);
        s0 = rotr(sched[(r-15) & 15], 7) ^ rotr(sched[(r-15) & 15], 18) ^
             (sched[(r-15) & 15] >> 3);
        w = s1 + sched[(r-7) & 15] + s0 + sched[r & 15];
        sched[r & 15] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (r = 0; r < 8; r++) hash_chain[r] = hash_chain[r] + v[r];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    block_bytes[byte_count[5:0]] = b;
    byte_count = byte_count + 64'd1;
    if (byte_count[5:0] == 6'd0) compress_block();
  endfunction

  // Pads the message, queues the eight digest words it yields and starts a
  // new message. The bit length is taken before the marker byte goes in.
  function automatic void finish_message();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    int           i;
    bit_len = byte_count << 3;
    absorb_byte(8'h80);
    while (byte_count[5:0] != 6'd56) absorb_byte(8'h00);
    for (i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
    for (i = 0; i < 8; i++) begin
      beat.word  = hash_chain[i];
      beat.index = i[2:0];
      beat.last  = (i == 7);
      pending_words.push_back(beat);
    end
    restart_hash();
  endfunction

  // Monitor and checker. Every input transfer goes through the predictor at
  // the edge where it completes, and every output transfer is compared with
  // the oldest predicted word. Sampling right after the edge sees the values
  // the block itself saw at that edge.
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_op == OP_FINISH) begin
          finish_message();
        end else begin
          absorb_byte(in_data_byte);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                   out_digest_word, out_word_index, out_last_word);
          mismatch_count++;
        end else begin
          want = pending_words.pop_front();
          if (out_digest_word !== want.word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     want.word, out_digest_word);
            mismatch_count++;
          end
          if (out_word_index !== want.index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     want.index, out_word_index);
            mismatch_count++;
          end
          if (out_last_word !== want.last) begin
            $display("%0t: last_word expected %0b actual %0b", $time,
                     want.last, out_last_word);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Receiver stall pattern. It switches now and then between four modes:
  // never stalling, stalling at random, stalling when the cycle count is a
  // multiple of four, and stalling in long runs. It ignores out_valid entirely.
  int stall_mode = 0;
  int stall_timer = 0;
  int stall_run = 0;
  int stall_cycle = 0;

  always @(posedge clk) begin
    stall_cycle++;
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_timer = $urandom_range(40, 300);
    end else begin
      stall_timer--;
    end
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= (stall_cycle % 4 == 0);
        default: begin
          // Positive run counts hold the stall, negative ones release it.
          if (stall_run == 0) begin
            stall_run = ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 20))
                                                    : -int'($urandom_range(1, 5));
          end
          if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run--;
          end else begin
            out_stall <= 1'b0;
            stall_run++;
          end
        end
      endcase
    end
  end

  // Sends one item and returns at the edge where its transfer completes.
  // Items go out in bursts; before each burst the sender pauses for a gap,
  // now and then long enough to cover a whole compression. The valid line
  // is only lowered for a gap and raised again at a later edge, and the
  // payload stays put while the block stalls.
  task automatic send_item(input logic op, input logic [7:0] data);
    int gap;
    if (idle_on && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                         : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Message bytes lean toward the all-zero and all-one values.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends a message of random bytes followed by a finish. The data byte on
  // the finish is random too, since the block must ignore it.
  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_item(OP_ABSORB, pick_byte());
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // A finish with nothing absorbed gives the digest of the empty string.
  task automatic test_empty_message();
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // The classic three-byte message.
  task automatic test_abc_message();
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
  endtask

  // Bytes at the edges of their range, with the finish carrying all ones in
  // its ignored data field.
  task automatic test_byte_extremes();
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h80);
    send_item(OP_ABSORB, 8'h7f);
    send_item(OP_FINISH, 8'hff);
  endtask

  // Two finishes in a row: the second one checks that the first returned
  // the block to the initial hash and a zero byte count.
  task automatic test_back_to_back_finish();
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hff);
  endtask

  // Message lengths around the padding boundary: 55 bytes still fit the
  // length field in the same block, 56 and 63 need a second padding block,
  // and 64 fills a block exactly before the finish.
  task automatic test_block_boundaries();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
  endtask

  // A stretch with no pauses on the input and no stalls on the output.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    send_message($urandom_range(20, 40));
    send_message($urandom_range(0, 10));
    send_message($urandom_range(60, 70));
    idle_on = 1'b1;
  endtask

  // Random messages until the item budget is spent. About one message in
  // five takes a length near a block or padding boundary; the rest are short.
  task automatic test_random_messages(input int stop_at);
    int len;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 10))
          0: len = 0;
          1: len = 1;
          2: len = 54;
          3: len = 55;
          4: len = 56;
          5: len = 57;
          6: len = 63;
          7: len = 64;
          8: len = 65;
          9: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 30);
      end
      send_message(len);
    end
  endtask

  // The byte count wraps only after 2^64 bytes, which no simulation can
  // reach; the predictor keeps the full 64-bit count all the same.
  initial begin
    restart_hash();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_abc_message();
    test_byte_extremes();
    test_back_to_back_finish();

    test_block_boundaries();
    test_steady_stream();
    test_random_messages(TOTAL_ITEMS);

    in_valid <= 1'b0;
    // Waiting on the clock here lets the monitor take in the last transfer before the
    // queue of expected words is looked at.
    @(posedge clk);
    // Wait for the last digest words, then give the block time to show any
    // stray output transfer.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sha256_stream_hasher regression: pass");
    end else begin
      $display("sha256_stream_hasher regression: fail");
    end
    $finish;
  end

  // Watchdog. A correct run needs a small fraction of this time even with
  // every gap and stall at its longest.
  initial begin
    #25_000_000;
    $display("sha256_stream_hasher regression: fail");
    $finish;
  end

endmodule

### sim.f
hw/rtl/shs_pkg.sv
hw/rtl/shs_round.sv
hw/rtl/sha256_stream_hasher.sv
tb/sv/sha256_stream_hasher_tb.sv
